### src/ukal_pkg.sv
// ----------------------------------------------------------------------------
// Unique key array list package
// Shared payload types, command and status codes, and the control and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ukal_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int KEY_W     = 32;
	localparam int MODE_W    = 3;
	localparam int POS_W     = 7;
	localparam int STATUS_W  = 3;
	localparam int IDX_W     = 6;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 3'd0,
		MODE_DELETE = 3'd1,
		MODE_INSERT = 3'd2,
		MODE_SEARCH = 3'd3,
		MODE_UPDATE = 3'd4,
		MODE_LIST   = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_BADPOS   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		IDX_ZERO,
		IDX_F,
		IDX_G,
		IDX_CNT,
		IDX_POS,
		IDX_PTR
	} idx_sel_t;

	typedef enum logic [1:0] {
		WR_COUNT,
		WR_POS,
		WR_F
	} wr_sel_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
		logic [KEY_W-1:0]  new_key;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    index;
		logic [KEY_W-1:0]    entry;
		logic                last;
	} rsp_t;

	typedef struct packed {
		logic     ld_in;
		logic     scan_start;
		logic     scan_step;
		logic     dn_start;
		logic     dn_step;
		logic     up_start;
		logic     up_step;
		logic     list_start;
		logic     list_rd;
		logic     res_ld;
		status_t  res_status;
		idx_sel_t res_idx;
		logic     res_list;
		logic     wr_en;
		wr_sel_t  wr_sel;
		logic     cnt_inc;
		logic     cnt_dec;
	} ctl_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              f_found;
		logic              g_found;
		logic              g_eq_f;
		logic              full;
		logic              bad_pos;
		logic              empty;
		logic              scan_done;
		logic              dn_done;
		logic              up_done;
		logic              rsp_free;
		logic              list_last;
	} dp_stat_t;

endpackage

### src/ukal_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ukal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/ukal_dp.sv
// ----------------------------------------------------------------------------
// Unique key array list datapath
// Key store, entry count, shared scan and shift pointer, match registers and the
// result register.
// ----------------------------------------------------------------------------
module ukal_dp #(
	parameter int DEPTH = ukal_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ukal_pkg::req_t     req,
	input  ukal_pkg::ctl_cmd_t ctl,
	output ukal_pkg::dp_stat_t stat,
	output ukal_pkg::rsp_t     rsp,
	output logic               rsp_valid,
	input  logic               rsp_stall
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ukal_pkg::req_t         req_q;
	ukal_pkg::rsp_t         rsp_q;
	logic                   rsp_valid_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          sp_q;
	logic [CW-1:0]          sp_dec;
	logic [CW:0]            sp_inc;
	logic                   scv_s1;
	logic [AW-1:0]          scidx_s1;
	logic                   wv_s1;
	logic [AW-1:0]          wa_s1;
	logic                   f_found_q;
	logic [AW-1:0]          f_idx_q;
	logic                   g_found_q;
	logic [AW-1:0]          g_idx_q;
	logic                   sp_lt_cnt;
	logic                   sp_gt_pos;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [ukal_pkg::KEY_W-1:0] rd_data;
	logic                   we;
	logic [AW-1:0]          wa;
	logic [ukal_pkg::KEY_W-1:0] wd;
	logic [ukal_pkg::IDX_W-1:0] res_idx;
	logic                   rsp_free;

	assign sp_dec    = sp_q - CW'(1);
	assign sp_inc    = {1'b0, sp_q} + (CW + 1)'(1);
	assign sp_lt_cnt = sp_q < cnt_q;
	assign sp_gt_pos = ukal_pkg::POS_W'(sp_q) > req_q.position;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(sp_q);
		if ((ctl.scan_step || ctl.dn_step) && sp_lt_cnt) begin
			rd_en = 1'b1;
		end else if (ctl.up_step && sp_gt_pos) begin
			rd_en   = 1'b1;
			rd_addr = AW'(sp_dec);
		end else if (ctl.list_rd) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		we = 1'b0;
		wa = wa_s1;
		wd = rd_data;
		if (wv_s1) begin
			we = 1'b1;
		end else if (ctl.wr_en) begin
			we = 1'b1;
			case (ctl.wr_sel)
				ukal_pkg::WR_COUNT: begin
					wa = AW'(cnt_q);
					wd = req_q.key;
				end
				ukal_pkg::WR_POS: begin
					wa = AW'(req_q.position);
					wd = req_q.key;
				end
				ukal_pkg::WR_F: begin
					wa = f_idx_q;
					wd = req_q.new_key;
				end
				default: begin
					wa = f_idx_q;
					wd = req_q.key;
				end
			endcase
		end
	end

	ukal_ram #(
		.WIDTH(ukal_pkg::KEY_W),
		.DEPTH(DEPTH)
	) u_key_store (
		.clk  (clk),
		.we   (we),
		.waddr(wa),
		.wdata(wd),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sp_q        <= '0;
			scv_s1      <= 1'b0;
			wv_s1       <= 1'b0;
			f_found_q   <= 1'b0;
			g_found_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.scan_start || ctl.list_start) begin
				sp_q <= '0;
			end else if (ctl.dn_start) begin
				sp_q <= CW'(f_idx_q) + CW'(1);
			end else if (ctl.up_start) begin
				sp_q <= cnt_q;
			end else if ((ctl.scan_step || ctl.dn_step) && sp_lt_cnt) begin
				sp_q <= sp_inc[CW-1:0];
			end else if (ctl.up_step && sp_gt_pos) begin
				sp_q <= sp_dec;
			end else if (ctl.res_ld && ctl.res_list) begin
				sp_q <= sp_inc[CW-1:0];
			end

			scv_s1 <= ctl.scan_step && sp_lt_cnt;
			wv_s1  <= (ctl.dn_step && sp_lt_cnt) || (ctl.up_step && sp_gt_pos);

			if (ctl.scan_start) begin
				f_found_q <= 1'b0;
				g_found_q <= 1'b0;
			end else if (scv_s1) begin
				if (!f_found_q && rd_data == req_q.key) begin
					f_found_q <= 1'b1;
				end
				if (!g_found_q && rd_data == req_q.new_key) begin
					g_found_q <= 1'b1;
				end
			end

			if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (ctl.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end

			if (ctl.res_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case (ctl.res_idx)
			ukal_pkg::IDX_F:   res_idx = ukal_pkg::IDX_W'(f_idx_q);
			ukal_pkg::IDX_G:   res_idx = ukal_pkg::IDX_W'(g_idx_q);
			ukal_pkg::IDX_CNT: res_idx = ukal_pkg::IDX_W'(cnt_q);
			ukal_pkg::IDX_POS: res_idx = req_q.position[ukal_pkg::IDX_W-1:0];
			ukal_pkg::IDX_PTR: res_idx = ukal_pkg::IDX_W'(sp_q);
			default:           res_idx = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_in) begin
			req_q <= req;
		end
		scidx_s1 <= AW'(sp_q);
		wa_s1    <= ctl.dn_step ? AW'(sp_dec) : AW'(sp_q);
		if (scv_s1 && !f_found_q && rd_data == req_q.key) begin
			f_idx_q <= scidx_s1;
		end
		if (scv_s1 && !g_found_q && rd_data == req_q.new_key) begin
			g_idx_q <= scidx_s1;
		end
		if (ctl.res_ld) begin
			rsp_q.status <= ctl.res_status;
			rsp_q.index  <= res_idx;
			rsp_q.entry  <= ctl.res_list ? rd_data : '0;
			rsp_q.last   <= ctl.res_list ? (sp_inc == {1'b0, cnt_q}) : 1'b1;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	assign stat.mode      = req_q.mode;
	assign stat.f_found   = f_found_q;
	assign stat.g_found   = g_found_q;
	assign stat.g_eq_f    = g_idx_q == f_idx_q;
	assign stat.full      = cnt_q == CW'(DEPTH);
	assign stat.bad_pos   = req_q.position > ukal_pkg::POS_W'(cnt_q);
	assign stat.empty     = cnt_q == '0;
	assign stat.scan_done = !sp_lt_cnt && !scv_s1;
	assign stat.dn_done   = !sp_lt_cnt && !wv_s1;
	assign stat.up_done   = !sp_gt_pos && !wv_s1;
	assign stat.rsp_free  = rsp_free;
	assign stat.list_last = sp_inc == {1'b0, cnt_q};

endmodule

### src/ukal_ctrl.sv
// ----------------------------------------------------------------------------
// Unique key array list controller
// Sequences the scan, shift, list and commit steps of one command.
// ----------------------------------------------------------------------------
module ukal_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  ukal_pkg::dp_stat_t stat,
	output ukal_pkg::ctl_cmd_t ctl
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SCAN     = 8'b0000_0010,
		S_DECIDE   = 8'b0000_0100,
		S_SHDN     = 8'b0000_1000,
		S_SHUP     = 8'b0001_0000,
		S_FIN      = 8'b0010_0000,
		S_LIST_RD  = 8'b0100_0000,
		S_LIST_OUT = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.ld_in      = 1'b1;
					ctl.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				ctl.scan_step = 1'b1;
				if (stat.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (stat.mode) inside
					ukal_pkg::MODE_APPEND, ukal_pkg::MODE_SEARCH,
					ukal_pkg::MODE_UPDATE: begin
						state_d = S_FIN;
					end
					ukal_pkg::MODE_DELETE: begin
						if (stat.f_found) begin
							ctl.dn_start = 1'b1;
							state_d      = S_SHDN;
						end else begin
							state_d = S_FIN;
						end
					end
					ukal_pkg::MODE_INSERT: begin
						if (!stat.f_found && !stat.full && !stat.bad_pos) begin
							ctl.up_start = 1'b1;
							state_d      = S_SHUP;
						end else begin
							state_d = S_FIN;
						end
					end
					ukal_pkg::MODE_LIST: begin
						if (stat.empty) begin
							state_d = S_FIN;
						end else begin
							ctl.list_start = 1'b1;
							state_d        = S_LIST_RD;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SHDN: begin
				ctl.dn_step = 1'b1;
				if (stat.dn_done) begin
					state_d = S_FIN;
				end
			end
			S_SHUP: begin
				ctl.up_step = 1'b1;
				if (stat.up_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.rsp_free) begin
					ctl.res_ld = 1'b1;
					state_d    = S_IDLE;
					unique case (stat.mode)
						ukal_pkg::MODE_APPEND: begin
							if (stat.f_found) begin
								ctl.res_status = ukal_pkg::ST_DUP;
								ctl.res_idx    = ukal_pkg::IDX_F;
							end else if (stat.full) begin
								ctl.res_status = ukal_pkg::ST_FULL;
							end else begin
								ctl.res_status = ukal_pkg::ST_OK;
								ctl.res_idx    = ukal_pkg::IDX_CNT;
								ctl.wr_en      = 1'b1;
								ctl.wr_sel     = ukal_pkg::WR_COUNT;
								ctl.cnt_inc    = 1'b1;
							end
						end
						ukal_pkg::MODE_DELETE: begin
							if (stat.f_found) begin
								ctl.res_status = ukal_pkg::ST_OK;
								ctl.res_idx    = ukal_pkg::IDX_F;
								ctl.cnt_dec    = 1'b1;
							end else begin
								ctl.res_status = ukal_pkg::ST_NOTFOUND;
							end
						end
						ukal_pkg::MODE_INSERT: begin
							if (stat.f_found) begin
								ctl.res_status = ukal_pkg::ST_DUP;
								ctl.res_idx    = ukal_pkg::IDX_F;
							end else if (stat.full) begin
								ctl.res_status = ukal_pkg::ST_FULL;
							end else if (stat.bad_pos) begin
								ctl.res_status = ukal_pkg::ST_BADPOS;
							end else begin
								ctl.res_status = ukal_pkg::ST_OK;
								ctl.res_idx    = ukal_pkg::IDX_POS;
								ctl.wr_en      = 1'b1;
								ctl.wr_sel     = ukal_pkg::WR_POS;
								ctl.cnt_inc    = 1'b1;
							end
						end
						ukal_pkg::MODE_SEARCH: begin
							if (stat.f_found) begin
								ctl.res_status = ukal_pkg::ST_OK;
								ctl.res_idx    = ukal_pkg::IDX_F;
							end else begin
								ctl.res_status = ukal_pkg::ST_NOTFOUND;
							end
						end
						ukal_pkg::MODE_UPDATE: begin
							if (!stat.f_found) begin
								ctl.res_status = ukal_pkg::ST_NOTFOUND;
							end else if (stat.g_found && !stat.g_eq_f) begin
								ctl.res_status = ukal_pkg::ST_DUP;
								ctl.res_idx    = ukal_pkg::IDX_G;
							end else begin
								ctl.res_status = ukal_pkg::ST_OK;
								ctl.res_idx    = ukal_pkg::IDX_F;
								ctl.wr_en      = 1'b1;
								ctl.wr_sel     = ukal_pkg::WR_F;
							end
						end
						default: begin
							ctl.res_status = ukal_pkg::ST_NOTFOUND;
						end
					endcase
				end
			end
			S_LIST_RD: begin
				ctl.list_rd = 1'b1;
				state_d     = S_LIST_OUT;
			end
			S_LIST_OUT: begin
				if (stat.rsp_free) begin
					ctl.res_ld     = 1'b1;
					ctl.res_list   = 1'b1;
					ctl.res_status = ukal_pkg::ST_OK;
					ctl.res_idx    = ukal_pkg::IDX_PTR;
					state_d        = stat.list_last ? S_IDLE : S_LIST_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/unique_key_array_list_unit.sv
// ----------------------------------------------------------------------------
// Unique key array list unit
// Holds up to DEPTH unique 32-bit keys in a compact ordered list and runs
// append, delete, insert, search, update and list commands on it.
// ----------------------------------------------------------------------------
// The block takes one command at a time and raises req_stall until that
// command has handed its last result to the output register; a reserved
// mode ends without a result. After taking the command, the block scans the
// occupied entries through the single read port of the key RAM, one entry per
// cycle, and then decides on the command. A delete then shifts the entries
// behind the removed key and an insert shifts the entries from the position
// upward. The result is then committed. A list command gives one result beat
// per entry, or a single not-found beat on an empty list; each entry is read
// after the previous beat is loaded, and rsp_stall holds commits and beats back.
module unique_key_array_list_unit #(
	parameter int DEPTH = ukal_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ukal_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ukal_pkg::rsp_t rsp
);

	ukal_pkg::ctl_cmd_t ctl;
	ukal_pkg::dp_stat_t stat;

	ukal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	ukal_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ctl      (ctl),
		.stat     (stat),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall)
	);

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_ld |-> (!rsp_valid || !rsp_stall))
		else $error("Result loaded over a stalled beat.");

	a_no_grow_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cnt_inc |-> !stat.full)
		else $error("Entry count grown past capacity.");

	a_list_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_stall && !rsp.last) |-> req_stall)
		else $error("New command taken in the middle of a list.");

endmodule

### tb/sv/unique_key_array_list_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unique key array list unit testbench
// Drives append, delete, insert, search, update and list commands into the
// unit with random bursts and gaps, stalls the result side on changing
// patterns, and checks every result beat against a built-in model of the
// key list. It covers the empty list, the full list, and every error status.
// ----------------------------------------------------------------------------
module unique_key_array_list_unit_test;

	localparam int DEPTH       = ukal_pkg::DEPTH_DEF;
	localparam int RAND_CMDS   = 170;
	localparam int QUIET_LIMIT = 5000;
	localparam int END_CYCLES  = 300;

	localparam logic [ukal_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
	localparam logic [ukal_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;

	typedef enum int {
		STALL_NONE,
		STALL_HALF,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ukal_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ukal_pkg::rsp_t rsp;

	ukal_pkg::req_t pending_cmds[$];
	ukal_pkg::rsp_t expected_beats[$];
	logic [ukal_pkg::KEY_W-1:0] list_keys[DEPTH];
	int list_count = 0;

	int cmds_issued = 0;
	int cmds_accepted = 0;
	int real_cmds = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic req_taken = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_left = 0;
	stall_style_t stall_style = STALL_NONE;

	unique_key_array_list_unit #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int find_entry(input logic [ukal_pkg::KEY_W-1:0] k);
		for (int i = 0; i < list_count; i++) begin
			if (list_keys[i] == k)
				return i;
		end
		return -1;
	endfunction

	task automatic post_beat(input ukal_pkg::status_t st, input int idx,
			input logic [ukal_pkg::KEY_W-1:0] ent, input logic lst);
		ukal_pkg::rsp_t r;
		r.status = st;
		r.index = ukal_pkg::IDX_W'(idx);
		r.entry = ent;
		r.last = lst;
		expected_beats.push_back(r);
	endtask

	task automatic apply_command(input ukal_pkg::req_t cmd);
		int f;
		int g;
		f = find_entry(cmd.key);
		case (cmd.mode)
			ukal_pkg::MODE_APPEND: begin
				if (f >= 0) begin
					post_beat(ukal_pkg::ST_DUP, f, '0, 1'b1);
				end else if (list_count >= DEPTH) begin
					post_beat(ukal_pkg::ST_FULL, 0, '0, 1'b1);
				end else begin
					list_keys[list_count] = cmd.key;
					post_beat(ukal_pkg::ST_OK, list_count, '0, 1'b1);
					list_count++;
				end
			end
			ukal_pkg::MODE_DELETE: begin
				if (f < 0) begin
					post_beat(ukal_pkg::ST_NOTFOUND, 0, '0, 1'b1);
				end else begin
					for (int i = f; i + 1 < list_count; i++)
						list_keys[i] = list_keys[i + 1];
					list_count--;
					post_beat(ukal_pkg::ST_OK, f, '0, 1'b1);
				end
			end
			ukal_pkg::MODE_INSERT: begin
				if (f >= 0) begin
					post_beat(ukal_pkg::ST_DUP, f, '0, 1'b1);
				end else if (list_count >= DEPTH) begin
					post_beat(ukal_pkg::ST_FULL, 0, '0, 1'b1);
				end else if (int'(cmd.position) > list_count) begin
					post_beat(ukal_pkg::ST_BADPOS, 0, '0, 1'b1);
				end else begin
					for (int i = list_count; i > int'(cmd.position); i--)
						list_keys[i] = list_keys[i - 1];
					list_keys[cmd.position] = cmd.key;
					list_count++;
					post_beat(ukal_pkg::ST_OK, int'(cmd.position), '0, 1'b1);
				end
			end
			ukal_pkg::MODE_SEARCH: begin
				if (f < 0)
					post_beat(ukal_pkg::ST_NOTFOUND, 0, '0, 1'b1);
				else
					post_beat(ukal_pkg::ST_OK, f, '0, 1'b1);
			end
			ukal_pkg::MODE_UPDATE: begin
				if (f < 0) begin
					post_beat(ukal_pkg::ST_NOTFOUND, 0, '0, 1'b1);
				end else begin
					g = find_entry(cmd.new_key);
					if (g >= 0 && g != f) begin
						post_beat(ukal_pkg::ST_DUP, g, '0, 1'b1);
					end else begin
						list_keys[f] = cmd.new_key;
						post_beat(ukal_pkg::ST_OK, f, '0, 1'b1);
					end
				end
			end
			ukal_pkg::MODE_LIST: begin
				if (list_count == 0) begin
					post_beat(ukal_pkg::ST_NOTFOUND, 0, '0, 1'b1);
				end else begin
					for (int i = 0; i < list_count; i++)
						post_beat(ukal_pkg::ST_OK, i, list_keys[i], i + 1 == list_count);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_beat(input ukal_pkg::rsp_t got);
		ukal_pkg::rsp_t want;
		if (expected_beats.size() == 0) begin
			report_mismatch($sformatf("unexpected beat status %0d index %0d entry %h last %0d",
				got.status, got.index, got.entry, got.last));
			return;
		end
		want = expected_beats.pop_front();
		if (got.status !== want.status || got.index !== want.index ||
				got.entry !== want.entry || got.last !== want.last)
			report_mismatch($sformatf(
				"status %0d/%0d index %0d/%0d entry %h/%h last %0d/%0d (got/want)",
				got.status, want.status, got.index, want.index,
				got.entry, want.entry, got.last, want.last));
	endtask

	// Request driver: bursts of back-to-back beats separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (gap_left > 0) begin
				req_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() > 0) begin
				req <= pending_cmds.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					if ($urandom_range(0, 3) == 0)
						gap_left <= 0;
					else if ($urandom_range(0, 7) == 0)
						gap_left <= $urandom_range(10, 30);
					else
						gap_left <= $urandom_range(1, 4);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(10, 150);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
			default:     rsp_stall <= (stall_left % 3 != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				apply_command(req);
				cmds_accepted++;
			end
			if (rsp_valid && !rsp_stall)
				check_beat(rsp);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("unique_key_array_list_unit_test failed");
					$finish;
				end
			end
		end
	end

	task automatic queue_cmd(input logic [ukal_pkg::MODE_W-1:0] mode,
			input logic [ukal_pkg::KEY_W-1:0] key,
			input logic [ukal_pkg::KEY_W-1:0] new_key,
			input logic [ukal_pkg::POS_W-1:0] pos);
		ukal_pkg::req_t cmd;
		cmd.mode = mode;
		cmd.key = key;
		cmd.new_key = new_key;
		cmd.position = pos;
		pending_cmds.push_back(cmd);
		cmds_issued++;
		if (mode <= ukal_pkg::MODE_LIST)
			real_cmds++;
	endtask

	task automatic wait_drained();
		while (cmds_accepted != cmds_issued || expected_beats.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [ukal_pkg::KEY_W-1:0] fresh_key();
		logic [ukal_pkg::KEY_W-1:0] k;
		k = $urandom;
		while (find_entry(k) >= 0)
			k = $urandom;
		return k;
	endfunction

	function automatic logic [ukal_pkg::KEY_W-1:0] pick_key(input int pct_present);
		if (list_count > 0 && $urandom_range(0, 99) < pct_present)
			return list_keys[$urandom_range(0, list_count - 1)];
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 7);
		return $urandom;
	endfunction

	task automatic fill_phase();
		int n;
		while (list_count < DEPTH) begin
			n = (DEPTH - list_count > 16) ? 16 : DEPTH - list_count;
			repeat (n) begin
				if ($urandom_range(0, 2) == 0)
					queue_cmd(ukal_pkg::MODE_INSERT, fresh_key(), $urandom,
						ukal_pkg::POS_W'($urandom_range(0, list_count)));
				else
					queue_cmd(ukal_pkg::MODE_APPEND, fresh_key(), $urandom,
						ukal_pkg::POS_W'($urandom));
			end
			wait_drained();
		end
		queue_cmd(ukal_pkg::MODE_APPEND, fresh_key(), '0, '0);
		queue_cmd(ukal_pkg::MODE_INSERT, list_keys[$urandom_range(0, DEPTH - 1)], '0, 7'd127);
		queue_cmd(ukal_pkg::MODE_INSERT, fresh_key(), '0, 7'd64);
		queue_cmd(ukal_pkg::MODE_UPDATE, list_keys[DEPTH - 1], list_keys[0], '0);
		queue_cmd(ukal_pkg::MODE_SEARCH, list_keys[DEPTH - 1], '0, '0);
		queue_cmd(ukal_pkg::MODE_LIST, '0, '0, '0);
		queue_cmd(ukal_pkg::MODE_DELETE, list_keys[0], '0, '0);
		queue_cmd(ukal_pkg::MODE_INSERT, fresh_key(), '0, '0);
		wait_drained();
	endtask

	task automatic mixed_phase();
		int pick;
		logic [ukal_pkg::KEY_W-1:0] k;
		logic [ukal_pkg::KEY_W-1:0] nk;
		logic [ukal_pkg::POS_W-1:0] pos;
		repeat ($urandom_range(8, 16)) begin
			pick = $urandom_range(0, 19);
			k = pick_key(55);
			nk = ($urandom_range(0, 9) == 0) ? k : pick_key(40);
			if ($urandom_range(0, 9) < 7)
				pos = ukal_pkg::POS_W'($urandom_range(0, list_count + 1));
			else
				pos = ukal_pkg::POS_W'($urandom_range(0, 127));
			if (pick < 4)
				queue_cmd(ukal_pkg::MODE_APPEND, k, nk, pos);
			else if (pick < 7)
				queue_cmd(ukal_pkg::MODE_DELETE, k, nk, pos);
			else if (pick < 11)
				queue_cmd(ukal_pkg::MODE_INSERT, k, nk, pos);
			else if (pick < 14)
				queue_cmd(ukal_pkg::MODE_SEARCH, k, nk, pos);
			else if (pick < 17)
				queue_cmd(ukal_pkg::MODE_UPDATE, k, nk, pos);
			else if (pick < 19)
				queue_cmd(ukal_pkg::MODE_LIST, k, nk, pos);
			else
				queue_cmd($urandom_range(0, 1) ? MODE_RSVD6 : MODE_RSVD7, k, nk, pos);
		end
		wait_drained();
	endtask

	initial begin
		int phase_no;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_cmd(ukal_pkg::MODE_LIST, '0, '0, '0);
		queue_cmd(ukal_pkg::MODE_SEARCH, '0, '0, '0);
		queue_cmd(ukal_pkg::MODE_DELETE, '0, '0, '0);
		queue_cmd(ukal_pkg::MODE_UPDATE, '0, 32'h1, '0);
		queue_cmd(ukal_pkg::MODE_INSERT, '0, '0, 7'd1);
		queue_cmd(ukal_pkg::MODE_INSERT, 32'hFFFF_FFFF, '0, 7'd0);
		queue_cmd(ukal_pkg::MODE_APPEND, 32'h0, '0, '0);
		queue_cmd(ukal_pkg::MODE_APPEND, 32'hFFFF_FFFF, '0, '0);
		queue_cmd(ukal_pkg::MODE_INSERT, 32'h1234_5678, '0, 7'd1);
		queue_cmd(ukal_pkg::MODE_INSERT, 32'h0000_0001, '0, 7'd3);
		queue_cmd(ukal_pkg::MODE_INSERT, 32'h0, '0, 7'd127);
		queue_cmd(ukal_pkg::MODE_INSERT, 32'hDEAD_BEEF, '0, 7'd127);
		queue_cmd(ukal_pkg::MODE_SEARCH, 32'h0, '0, '0);
		queue_cmd(ukal_pkg::MODE_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		queue_cmd(ukal_pkg::MODE_UPDATE, 32'h0, 32'h1234_5678, '0);
		queue_cmd(ukal_pkg::MODE_UPDATE, 32'h1, 32'hA5A5_A5A5, '0);
		queue_cmd(ukal_pkg::MODE_UPDATE, 32'h5A5A_5A5A, 32'h7, '0);
		queue_cmd(ukal_pkg::MODE_DELETE, 32'h1234_5678, '0, '0);
		queue_cmd(ukal_pkg::MODE_DELETE, 32'h1234_5678, '0, '0);
		queue_cmd(ukal_pkg::MODE_LIST, '0, '0, '0);
		queue_cmd(MODE_RSVD6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127);
		queue_cmd(MODE_RSVD7, '0, '0, '0);
		queue_cmd(ukal_pkg::MODE_DELETE, 32'hFFFF_FFFF, '0, '0);
		queue_cmd(ukal_pkg::MODE_LIST, '0, '0, '0);
		wait_drained();

		phase_no = 0;
		while (real_cmds < RAND_CMDS) begin
			if (phase_no == 2) begin
				fill_phase();
			end else if (list_count > 40 && $urandom_range(0, 1) == 0) begin
				repeat ($urandom_range(4, 10))
					queue_cmd(ukal_pkg::MODE_DELETE, pick_key(90), $urandom,
						ukal_pkg::POS_W'($urandom));
				wait_drained();
			end else begin
				mixed_phase();
			end
			phase_no++;
		end

		repeat (END_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_beats.size() == 0)
			$display("unique_key_array_list_unit_test passed");
		else
			$display("unique_key_array_list_unit_test failed");
		$finish;
	end

endmodule

### unique_key_array_list_unit.f
src/ukal_pkg.sv
src/ukal_ram.sv
src/ukal_dp.sv
src/ukal_ctrl.sv
src/unique_key_array_list_unit.sv
tb/sv/unique_key_array_list_unit_test.sv
